// ===== hdl/okl_pkg.sv =====
// Shared constants, codes and state type for the ordered key list engine.
// No dependencies; imported by okl_array, ordered_key_list_engine_core, okl_list_checker and tb_top.
package okl_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int KEY_W        = 32;
   localparam int OP_W         = 3;
   localparam int POS_W        = 6;
   localparam int STATUS_W     = 2;
   localparam int INDEX_W      = 4;
   localparam int COUNT_W      = 5;
   localparam int REQ_DATA_W   = 48;
   localparam int RSP_DATA_W   = 16;

   localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
   localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BADPOS   = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_INS_RD,
      ST_INS_WR,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_DONE
   } okl_state_type;

endpackage

// ===== hdl/okl_array.sv =====
// Key storage: single write port, single read port with registered read data.
// Depends on okl_pkg for the key width.
module okl_array
   import okl_pkg::*;
#(
   parameter int DEPTH = CAPACITY_DEF,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [KEY_W-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [KEY_W-1:0] rd_data
);

   logic [KEY_W-1:0] mem [DEPTH];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ordered_key_list_engine_core.sv =====
// Ordered key list engine: sequencer that walks the key store one entry per step.
// Depends on okl_pkg and okl_array.
//
// channel  direction  signals                     payload
// req      in         req_tvalid/tready/tdata     operation, key, position
// rsp      out        rsp_tvalid/tready/tdata     status, found_index, entry_count
//
// Append, clear and rejected requests go from decode straight to the done state.
// Search and delete scan from the front, delete then shifting later keys down; insert shifts keys up from the end;
// each step is one read of the store's single read port and one compare or write.
// Reset empties the list; stored keys are not cleared. The result register holds
// until taken; a new request is taken once the previous result has been loaded.
module ordered_key_list_engine_core
   import okl_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // operation[2:0], key[34:3], position[40:35]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // status[1:0], found_index[5:2], entry_count[10:6]
);

   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   okl_state_type       state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [CW-1:0]       found_ff, found_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [KEY_W-1:0]    wr_data;
   logic [AW-1:0]       rd_addr;
   logic [KEY_W-1:0]    rd_data;
   logic [CW-1:0]       idx_inc;
   logic [CW-1:0]       idx_dec;
   logic                list_full;
   logic                pos_bad;

   okl_array #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_array (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign idx_inc   = CW'(idx_ff + 1'b1);
   assign idx_dec   = CW'(idx_ff - 1'b1);
   assign list_full = (count_ff == CW'(CAPACITY));
   assign pos_bad   = (CMPW'(pos_ff) > CMPW'(count_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = AW'(idx_ff);
      wr_data       = key_ff;
      rd_addr       = AW'(idx_ff);
      req_tready    = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in     = req_tdata[2:0];
               key_in    = req_tdata[34:3];
               pos_in    = req_tdata[40:35];
               status_in = STAT_OK;
               found_in  = '0;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_DONE;
            case (op_ff) inside
               OP_APPEND: begin
                  if (list_full) begin
                     status_in = STAT_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = AW'(count_ff);
                     count_in = CW'(count_ff + 1'b1);
                  end
               end
               OP_INSERT: begin
                  if (list_full) begin
                     status_in = STAT_FULL;
                  end else if (pos_bad) begin
                     status_in = STAT_BADPOS;
                  end else begin
                     idx_in   = count_ff;
                     state_in = ST_INS_RD;
                  end
               end
               OP_DELETE, OP_SEARCH: begin
                  idx_in   = '0;
                  state_in = ST_SCAN_RD;
               end
               OP_CLEAR: begin
                  count_in = '0;
               end
               default: begin
               end
            endcase
         end
         ST_SCAN_RD: begin
            if (idx_ff == count_ff) begin
               status_in = STAT_NOTFOUND;
               state_in  = ST_DONE;
            end else begin
               rd_addr  = AW'(idx_ff);
               state_in = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            if (rd_data == key_ff) begin
               if (op_ff == OP_SEARCH) begin
                  found_in = idx_ff;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DEL_RD;
               end
            end else begin
               idx_in   = idx_inc;
               state_in = ST_SCAN_RD;
            end
         end
         ST_INS_RD: begin
            if (CMPW'(idx_ff) == CMPW'(pos_ff)) begin
               wr_en    = 1'b1;
               wr_addr  = AW'(idx_ff);
               count_in = CW'(count_ff + 1'b1);
               state_in = ST_DONE;
            end else begin
               rd_addr  = AW'(idx_dec);
               state_in = ST_INS_WR;
            end
         end
         ST_INS_WR: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(idx_ff);
            wr_data  = rd_data;
            idx_in   = idx_dec;
            state_in = ST_INS_RD;
         end
         ST_DEL_RD: begin
            if (idx_inc == count_ff) begin
               count_in = CW'(count_ff - 1'b1);
               state_in = ST_DONE;
            end else begin
               rd_addr  = AW'(idx_inc);
               state_in = ST_DEL_WR;
            end
         end
         ST_DEL_WR: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(idx_ff);
            wr_data  = rd_data;
            idx_in   = idx_inc;
            state_in = ST_DEL_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_index_in  = INDEX_W'(found_ff);
               rsp_count_in  = COUNT_W'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_count_ff, rsp_index_ff, rsp_status_ff};

endmodule

// ===== tb/okl_list_checker.sv =====
// Scoreboard for the ordered key list engine: watches the req and rsp streams,
// predicts every response from its own model of the key list and compares fields.
// Depends on okl_pkg for widths and operation and status codes.
module okl_list_checker
   import okl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // operation[2:0], key[34:3], position[40:35]
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // status[1:0], found_index[5:2], entry_count[10:6]
   output int                    error_count,
   output int                    pending,
   output int                    results_checked,
   output int                    ok_seen,
   output int                    full_seen,
   output int                    badpos_seen,
   output int                    notfound_seen,
   output int                    peak_fill
);

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  found_index;
      logic [COUNT_W-1:0]  entry_count;
   } list_result_type;

   logic [KEY_W-1:0] key_store [CAPACITY_DEF];
   int unsigned      key_count;
   list_result_type  expected_results [$];
   list_result_type  got;
   list_result_type  want;
   int               err_total;
   int               checked_total;
   int               status_tally [4];
   int               fill_max;

   function automatic list_result_type apply_list_op(input logic [OP_W-1:0]  op,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [POS_W-1:0] pos);
      list_result_type r;
      int              hit;
      int              j;
      r.status      = STAT_OK;
      r.found_index = '0;
      hit           = -1;
      case (op) inside
         OP_APPEND: begin
            if (key_count >= CAPACITY_DEF) begin
               r.status = STAT_FULL;
            end else begin
               key_store[key_count] = key;
               key_count++;
            end
         end
         OP_INSERT: begin
            if (key_count >= CAPACITY_DEF) begin
               r.status = STAT_FULL;
            end else if (pos > key_count) begin
               r.status = STAT_BADPOS;
            end else begin
               for (j = key_count; j > pos; j--) key_store[j] = key_store[j-1];
               key_store[pos] = key;
               key_count++;
            end
         end
         OP_DELETE, OP_SEARCH: begin
            for (j = 0; j < key_count; j++) begin
               if (hit < 0 && key_store[j] == key) hit = j;
            end
            if (hit < 0) begin
               r.status = STAT_NOTFOUND;
            end else if (op == OP_SEARCH) begin
               r.found_index = hit[INDEX_W-1:0];
            end else begin
               for (j = hit; j + 1 < key_count; j++) key_store[j] = key_store[j+1];
               key_count--;
            end
         end
         OP_CLEAR: begin
            key_count = 0;
         end
         default: begin
         end
      endcase
      r.entry_count = key_count[COUNT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         key_count     = 0;
         err_total     = 0;
         checked_total = 0;
         fill_max      = 0;
         status_tally  = '{default: 0};
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status      = rsp_tdata[1:0];
            got.found_index = rsp_tdata[5:2];
            got.entry_count = rsp_tdata[10:6];
            if (expected_results.size() == 0) begin
               err_total++;
               $display("%0t: unexpected response status=%0d index=%0d count=%0d", $time,
                        got.status, got.found_index, got.entry_count);
            end else begin
               want = expected_results.pop_front();
               checked_total++;
               status_tally[want.status]++;
               if (got.status !== want.status || got.found_index !== want.found_index ||
                   got.entry_count !== want.entry_count) begin
                  err_total++;
                  $display({"%0t: mismatch expected status=%0d index=%0d count=%0d, ",
                            "got status=%0d index=%0d count=%0d"},
                           $time, want.status, want.found_index, want.entry_count,
                           got.status, got.found_index, got.entry_count);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_results.push_back(apply_list_op(req_tdata[2:0], req_tdata[34:3],
                                                     req_tdata[40:35]));
            if (key_count > fill_max) fill_max = key_count;
         end
      end
      error_count     <= err_total;
      pending         <= expected_results.size();
      results_checked <= checked_total;
      ok_seen         <= status_tally[STAT_OK];
      full_seen       <= status_tally[STAT_FULL];
      badpos_seen     <= status_tally[STAT_BADPOS];
      notfound_seen   <= status_tally[STAT_NOTFOUND];
      peak_fill       <= fill_max;
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for ordered_key_list_engine_core: drives directed and random list
// requests with random gaps and response stalls, then reports the verdict.
// Depends on okl_pkg, ordered_key_list_engine_core and okl_list_checker.
module tb_top;
   import okl_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
   localparam logic [KEY_W-1:0] KEY_MIN   = 32'h8000_0000;
   localparam logic [KEY_W-1:0] KEY_MAX   = 32'h7FFF_FFFF;
   localparam logic [KEY_W-1:0] KEY_ONES  = 32'hFFFF_FFFF;
   localparam int RANDOM_ITEMS = 1030;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int error_count, pending, results_checked, peak_fill;
   int ok_seen, full_seen, badpos_seen, notfound_seen;
   int requests_sent;
   int rsp_hold;
   int rsp_draw;
   bit quiet_phase = 1'b0;
   logic [KEY_W-1:0] key_pool [8];

   always #1 clock = ~clock;

   ordered_key_list_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   okl_list_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .error_count     (error_count),
      .pending         (pending),
      .results_checked (results_checked),
      .ok_seen         (ok_seen),
      .full_seen       (full_seen),
      .badpos_seen     (badpos_seen),
      .notfound_seen   (notfound_seen),
      .peak_fill       (peak_fill)
   );

   // after each response transfer, randomly drop ready for a stall, except in quiet phases
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= $urandom_range(0, 3);
      end else if (rsp_tready) begin
         if (rsp_tvalid) begin
            rsp_draw = quiet_phase ? 0 : $urandom_range(0, 3);
            if (rsp_draw != 0) begin
               rsp_tready <= 1'b0;
               rsp_hold   <= rsp_draw - 1;
            end
         end
      end else if (rsp_hold == 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_hold <= rsp_hold - 1;
      end
   end

   task automatic send_request(input logic [OP_W-1:0]  op,
                               input logic [KEY_W-1:0] key,
                               input logic [POS_W-1:0] pos);
      int gap;
      gap = quiet_phase ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-OP_W-KEY_W-POS_W){1'b0}}, pos, key, op};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   task automatic send_random_request();
      int sel;
      logic [OP_W-1:0] op;
      logic [POS_W-1:0] pos;
      sel = $urandom_range(0, 99);
      if (sel < 34)      op = OP_APPEND;
      else if (sel < 54) op = OP_INSERT;
      else if (sel < 72) op = OP_DELETE;
      else if (sel < 93) op = OP_SEARCH;
      else if (sel < 95) op = OP_CLEAR;
      else               op = OP_W'($urandom_range(OP_SPARE_5, OP_SPARE_7));
      if ($urandom_range(0, 4) == 0) pos = POS_W'($urandom_range(0, 63));
      else                           pos = POS_W'($urandom_range(0, CAPACITY_DEF + 1));
      send_request(op, pick_key(), pos);
   endtask

   initial begin
      requests_sent = 0;
      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      key_pool[2] = '0;
      key_pool[3] = KEY_ONES;
      for (int i = 4; i < 8; i++) key_pool[i] = $urandom;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list, bad position, inserts at both ends
      send_request(OP_SEARCH, 32'd5, '0);
      send_request(OP_DELETE, 32'd5, '0);
      send_request(OP_INSERT, 32'd1, 6'd1);
      send_request(OP_INSERT, KEY_MIN, 6'd0);
      send_request(OP_INSERT, KEY_MAX, 6'd1);
      send_request(OP_INSERT, '0, 6'd0);
      send_request(OP_SEARCH, KEY_MAX, 6'd63);
      send_request(OP_DELETE, '0, '0);
      send_request(OP_INSERT, KEY_ONES, 6'd63);
      send_request(OP_SPARE_5, KEY_ONES, 6'd63);
      send_request(OP_SPARE_7, KEY_MIN, 6'd0);
      // fill to capacity, then hit the full list
      send_request(OP_APPEND, KEY_ONES, '0);
      for (int i = 0; i < CAPACITY_DEF - 3; i++) send_request(OP_APPEND, $urandom, '0);
      send_request(OP_APPEND, 32'h1234_5678, '0);
      send_request(OP_INSERT, 32'h1234_5678, 6'd40);
      send_request(OP_DELETE, KEY_MAX, '0);
      send_request(OP_CLEAR, KEY_ONES, 6'd63);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 128 == 0) begin
            quiet_phase = ($urandom_range(0, 3) == 0);
            key_pool[$urandom_range(4, 7)] = $urandom;
         end
         send_random_request();
      end
      req_tvalid <= 1'b0;
      quiet_phase = 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2 * CAPACITY_DEF + 8) @(posedge clock);

      $display("sent %0d requests, checked %0d responses, peak list fill %0d",
               requests_sent, results_checked, peak_fill);
      $display("responses by status: ok %0d, full %0d, bad position %0d, not found %0d",
               ok_seen, full_seen, badpos_seen, notfound_seen);
      if (error_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== ordered_key_list_engine_core.f =====
hdl/okl_pkg.sv
hdl/okl_array.sv
hdl/ordered_key_list_engine_core.sv
tb/okl_list_checker.sv
tb/tb_top.sv
